/* rtl/core/spimbs_pkg.sv */
// Shared types, codes and helpers for the SPI master byte shifter.
`default_nettype none
package spimbs_pkg;

   localparam int BITS_PER_WORD = 8;
   localparam int BIT_IDX_W     = $clog2(BITS_PER_WORD);
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 16;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_OPEN  = 3'd1,
      OP_CLOSE = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_OPEN_WAIT  = 3'd1,
      PH_CLOSE_WAIT = 3'd2,
      PH_FIRST      = 3'd3,
      PH_SECOND     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_ALREADY_OPEN = 2'd1,
      ST_BUSY        = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_CLK_MODE    = 3'd0,
      REG_LSB_FIRST   = 3'd1,
      REG_HALF_PERIOD = 3'd2,
      REG_CS_DELAY    = 3'd3,
      REG_CS_ACTIVE   = 3'd4,
      REG_FULL_DUPLEX = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [1:0]  clk_mode;
      logic        lsb_first;
      logic [15:0] half_period_ticks;
      logic [15:0] cs_delay_ticks;
      logic        cs_active_level;
      logic        full_duplex;
   } cfg_type;

   // First member lands in the top bits, so sck_level sits at bit 0.
   typedef struct packed {
      logic [1:0] status;
      logic       engine_busy;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       cs_level;
      logic       mosi_level;
      logic       sck_level;
   } rsp_type;

   // Returns {mosi, shifted tx byte}.
   function automatic logic [8:0] put_bit(input logic [7:0] tx, input logic lsb);
      logic [8:0] res;
      if (lsb) begin
         res = {tx[0], 1'b0, tx[7:1]};
      end else begin
         res = {tx[7], tx[6:0], 1'b0};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/spi_master_byte_shifter.sv */
// SPI master byte shifter, top level: register port, engine and result buffer.
// Each request transfer is one time tick (op 0, carrying the MISO level) or one
// command (open, close, write byte, read byte), and produces exactly one response
// transfer with the SCK, MOSI and CS pin levels after it, the received byte when a
// reported byte finishes, the busy flag and a refusal status. One item is taken
// per clock cycle while req_tready is high; the engine updates its state in the
// accept cycle and the response is registered in the two-entry output stage, so
// requests keep flowing while a response waits; req_tready drops only once both
// entries hold unclaimed responses. Registers: 0x00 clk_mode, 0x04 lsb_first,
// 0x08 half_period_ticks, 0x0C cs_delay_ticks, 0x10 cs_active_level,
// 0x14 full_duplex; write them only while idle.
`default_nettype none
module spi_master_byte_shifter
   import spimbs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [2:0] op, [10:3] tx_byte, [11] miso_level, [15:12] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] sck_level, [1] mosi_level, [2] cs_level, [10:3] rx_byte, [11] rx_valid,
   // [12] engine_busy, [14:13] status, [15] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cfg_type     cfg_ff;
   logic        csr_write;
   reg_idx_type csr_idx;
   logic        accept;
   logic        buf_ready;
   rsp_type     eng_result;
   rsp_type     rsp_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clk_mode          <= 2'd0;
         cfg_ff.lsb_first         <= 1'b0;
         cfg_ff.half_period_ticks <= 16'd1;
         cfg_ff.cs_delay_ticks    <= 16'd1;
         cfg_ff.cs_active_level   <= 1'b0;
         cfg_ff.full_duplex       <= 1'b1;
      end else if (csr_write) begin
         case (csr_idx)
            REG_CLK_MODE:    cfg_ff.clk_mode          <= csr_pwdata[1:0];
            REG_LSB_FIRST:   cfg_ff.lsb_first         <= csr_pwdata[0];
            REG_HALF_PERIOD: cfg_ff.half_period_ticks <= csr_pwdata[15:0];
            REG_CS_DELAY:    cfg_ff.cs_delay_ticks    <= csr_pwdata[15:0];
            REG_CS_ACTIVE:   cfg_ff.cs_active_level   <= csr_pwdata[0];
            REG_FULL_DUPLEX: cfg_ff.full_duplex       <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         REG_CLK_MODE:    csr_prdata = CSR_DATA_W'(cfg_ff.clk_mode);
         REG_LSB_FIRST:   csr_prdata = CSR_DATA_W'(cfg_ff.lsb_first);
         REG_HALF_PERIOD: csr_prdata = CSR_DATA_W'(cfg_ff.half_period_ticks);
         REG_CS_DELAY:    csr_prdata = CSR_DATA_W'(cfg_ff.cs_delay_ticks);
         REG_CS_ACTIVE:   csr_prdata = CSR_DATA_W'(cfg_ff.cs_active_level);
         REG_FULL_DUPLEX: csr_prdata = CSR_DATA_W'(cfg_ff.full_duplex);
         default:         csr_prdata = '0;
      endcase
   end

   assign req_tready = buf_ready;
   assign accept     = req_tvalid & buf_ready;

   spimbs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .op         (req_tdata[2:0]),
      .tx_byte    (req_tdata[10:3]),
      .miso_level (req_tdata[11]),
      .result     (eng_result)
   );

   spimbs_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (eng_result),
      .push_ready (buf_ready),
      .out_valid  (rsp_tvalid),
      .out_data   (rsp_data),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {1'b0, rsp_data};

endmodule
`default_nettype wire

/* rtl/core/spimbs_engine.sv */
// Pin timing and shift engine: state registers and per-item next-state logic.
`default_nettype none
module spimbs_engine
   import spimbs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       accept,
   input  wire logic [2:0] op,
   input  wire logic [7:0] tx_byte,
   input  wire logic       miso_level,
   output rsp_type         result
);

   logic                 open_ff, open_in;
   logic [7:0]           tx_ff, tx_in;
   logic [7:0]           rx_ff, rx_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   phase_type            phase_ff, phase_in;
   logic [15:0]          wait_ff, wait_in;
   logic                 report_ff, report_in;
   logic                 sck_ff, sck_in;
   logic                 mosi_ff, mosi_in;
   logic                 cs_ff, cs_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         tx_ff     <= '0;
         rx_ff     <= '0;
         bit_ff    <= '0;
         phase_ff  <= PH_IDLE;
         wait_ff   <= '0;
         report_ff <= 1'b0;
         sck_ff    <= 1'b0;
         mosi_ff   <= 1'b1;
         cs_ff     <= 1'b1;
      end else if (accept) begin
         open_ff   <= open_in;
         tx_ff     <= tx_in;
         rx_ff     <= rx_in;
         bit_ff    <= bit_in;
         phase_ff  <= phase_in;
         wait_ff   <= wait_in;
         report_ff <= report_in;
         sck_ff    <= sck_in;
         mosi_ff   <= mosi_in;
         cs_ff     <= cs_in;
      end
   end

   always_comb begin
      logic [15:0] half_len;
      logic [15:0] wc;
      logic [7:0]  bb_src;
      logic [8:0]  pb;
      logic        do_begin;
      logic [1:0]  st;
      logic        rxv;
      logic [7:0]  rxo;

      half_len  = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
      open_in   = open_ff;
      tx_in     = tx_ff;
      rx_in     = rx_ff;
      bit_in    = bit_ff;
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      report_in = report_ff;
      sck_in    = sck_ff;
      mosi_in   = mosi_ff;
      cs_in     = cs_ff;
      wc        = wait_ff;
      bb_src    = tx_ff;
      do_begin  = 1'b0;
      st        = ST_OK;
      rxv       = 1'b0;
      rxo       = 8'd0;

      case (op)
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (wc != 16'd0) begin
                  wc = wc - 16'd1;
               end
               wait_in = wc;
               if (wc == 16'd0) begin
                  case (phase_ff)
                     PH_OPEN_WAIT: begin
                        phase_in = PH_IDLE;
                     end
                     PH_CLOSE_WAIT: begin
                        mosi_in  = 1'b1;
                        phase_in = PH_IDLE;
                     end
                     PH_FIRST: begin
                        sck_in   = cfg.clk_mode[0] ? cfg.clk_mode[1] : ~cfg.clk_mode[1];
                        phase_in = PH_SECOND;
                        wait_in  = half_len;
                     end
                     default: begin
                        rx_in = cfg.lsb_first ? {miso_level, rx_ff[7:1]}
                                              : {rx_ff[6:0], miso_level};
                        if (!cfg.clk_mode[0]) begin
                           sck_in = cfg.clk_mode[1];
                        end
                        if (bit_ff == BIT_IDX_W'(BITS_PER_WORD - 1)) begin
                           phase_in = PH_IDLE;
                           bit_in   = '0;
                           if (report_ff) begin
                              rxv = 1'b1;
                              rxo = rx_in;
                           end
                        end else begin
                           bit_in   = bit_ff + BIT_IDX_W'(1);
                           bb_src   = tx_ff;
                           do_begin = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         OP_OPEN, OP_CLOSE, OP_WRITE, OP_READ: begin
            if (phase_ff != PH_IDLE) begin
               st = ST_BUSY;
            end else if (op == OP_OPEN) begin
               if (open_ff) begin
                  st = ST_ALREADY_OPEN;
               end else begin
                  open_in  = 1'b1;
                  cs_in    = cfg.cs_active_level;
                  wait_in  = cfg.cs_delay_ticks;
                  phase_in = (cfg.cs_delay_ticks != 16'd0) ? PH_OPEN_WAIT : PH_IDLE;
               end
            end else if (op == OP_CLOSE) begin
               open_in = 1'b0;
               cs_in   = ~cfg.cs_active_level;
               wait_in = cfg.cs_delay_ticks;
               if (cfg.cs_delay_ticks != 16'd0) begin
                  phase_in = PH_CLOSE_WAIT;
               end else begin
                  mosi_in  = 1'b1;
                  phase_in = PH_IDLE;
               end
            end else begin
               bb_src    = (op == OP_WRITE) ? tx_byte : 8'd0;
               rx_in     = 8'd0;
               bit_in    = '0;
               report_in = (op == OP_READ) || cfg.full_duplex;
               do_begin  = 1'b1;
            end
         end
         default: begin
         end
      endcase

      pb = put_bit(bb_src, cfg.lsb_first);
      if (do_begin) begin
         if (cfg.clk_mode[0]) begin
            sck_in = ~cfg.clk_mode[1];
         end
         mosi_in  = pb[8];
         tx_in    = pb[7:0];
         phase_in = PH_FIRST;
         wait_in  = half_len;
      end

      result.status      = st;
      result.engine_busy = (phase_in != PH_IDLE);
      result.rx_valid    = rxv;
      result.rx_byte     = rxo;
      result.cs_level    = cs_in;
      result.mosi_level  = mosi_in;
      result.sck_level   = sck_in;
   end

endmodule
`default_nettype wire

/* rtl/core/spimbs_out_buf.sv */
// Result register with a skid stage between the engine and the result channel.
`default_nettype none
module spimbs_out_buf
   import spimbs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         push_ready,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_ready
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || out_ready) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign push_ready = ~skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

endmodule
`default_nettype wire

/* rtl/core/spimbs_checker.sv */
// Port-level checks for the SPI master byte shifter, bound to the top level.
`default_nettype none
module spimbs_checker
   import spimbs_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no response pending");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:13] != 2'b11)
      else $error("undefined status code");

   a_rx_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> !rsp_tdata[12] && rsp_tdata[14:13] == ST_OK)
      else $error("received byte reported while busy or refused");

endmodule

bind spi_master_byte_shifter spimbs_checker u_spimbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
